// ===== hw/rtl/bfa_pkg.sv =====
// bfa_pkg: shared constants for the bitmap frame allocator.
// Command and status codes, field widths and parameter defaults.
// No dependencies.
package bfa_pkg;

	// parameter defaults
	localparam int unsigned MAX_FRAMES_DEF  = 4096;
	localparam int unsigned FRAME_SHIFT_DEF = 12;
	localparam int unsigned WORD_BITS_DEF   = 64;

	// fixed field widths
	localparam int unsigned CMD_W    = 3;
	localparam int unsigned FNUM_W   = 12;
	localparam int unsigned PADDR_W  = 24;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CFG_W    = 13;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ALLOC    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FREE     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MARK     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TEST     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_MARK_ALL = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

endpackage

// ===== hw/rtl/bfa_ram.sv =====
// bfa_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bfa_ram #(
	parameter int unsigned WIDTH  = 64,
	parameter int unsigned DEPTH  = 64,
	parameter int unsigned ADDR_W = 6
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/bitmap_frame_allocator.sv =====
// bitmap_frame_allocator: first-fit allocator over a used/free bitmap of frames.
// Depends on bfa_pkg and bfa_ram (bitmap store).
//
//   channel   signals                                         direction
//   cfg       cfg_we, cfg_wdata                               write only
//   in        in_valid, in_stall, command, frame_number,      request in
//             phys_address
//   out       out_valid, out_stall, status, result_frame,     result out
//             result_address, frame_used
//
// One request at a time. An unknown command or an out-of-range request needs no
// bitmap access; free and mark read, modify and write back the word, test reads it;
// allocate reads one word per cycle and checks each as it returns, over at most
// ceil(min(frames_in_use, MAX_FRAMES) / WORD_BITS) words. The input stays stalled
// until the result has moved from the holding register to the output register.
// Mark-all and reset sweep ones over the bitmap, one word per cycle, and no request
// is taken meanwhile. The output register keeps one result while the output is
// stalled; the holding register keeps a second, and the input stalls while it holds
// one. MAX_FRAMES and WORD_BITS must be powers of two; the block does not enforce it.
module bitmap_frame_allocator #(
	parameter int unsigned MAX_FRAMES  = bfa_pkg::MAX_FRAMES_DEF,
	parameter int unsigned FRAME_SHIFT = bfa_pkg::FRAME_SHIFT_DEF,
	parameter int unsigned WORD_BITS   = bfa_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bfa_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bfa_pkg::CMD_W-1:0]     command,
	input  logic [bfa_pkg::FNUM_W-1:0]    frame_number,
	input  logic [bfa_pkg::PADDR_W-1:0]   phys_address,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bfa_pkg::STATUS_W-1:0]  status,
	output logic [bfa_pkg::FNUM_W-1:0]    result_frame,
	output logic [bfa_pkg::PADDR_W-1:0]   result_address,
	output logic                          frame_used
);
	import bfa_pkg::*;

	localparam int unsigned NWORDS   = MAX_FRAMES / WORD_BITS;
	localparam int unsigned ADDR_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int unsigned BIT_W    = $clog2(WORD_BITS);
	localparam int unsigned LIM_R    = $clog2(MAX_FRAMES + 1);
	localparam int unsigned LIM_W    = (LIM_R > CFG_W) ? LIM_R : CFG_W;
	localparam int unsigned FA_W     = PADDR_W - FRAME_SHIFT;
	localparam int unsigned CMP_A    = (LIM_W > FA_W) ? LIM_W : FA_W;
	localparam int unsigned CMP_W    = (CMP_A > FNUM_W) ? CMP_A : FNUM_W;
	localparam int unsigned RADDR_W  = LIM_W + FRAME_SHIFT;

	// sequencer state codes
	localparam logic [1:0] ST_FILL = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_RMW  = 2'd3;

	// index of the single set bit
	function automatic logic [BIT_W-1:0] onehot_idx(input logic [WORD_BITS-1:0] oh);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (oh[b]) begin
				idx = idx | BIT_W'(b);
			end
		end
		return idx;
	endfunction

	logic [1:0]            state_q;
	logic [CFG_W-1:0]      cfg_q;
	logic [ADDR_W-1:0]     fill_q;
	logic [CMD_W-1:0]      op_q;
	logic [BIT_W-1:0]      bit_q;

	// scan issue pointer and the word in flight
	logic [ADDR_W-1:0]     issue_w_q;
	logic [LIM_W-1:0]      base_q;
	logic                  vld_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [LIM_W-1:0]      base_s1;
	logic [WORD_BITS-1:0]  mask_s1;

	// result holding register and output register
	logic                  res_pend_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [FNUM_W-1:0]     res_frame_q;
	logic [PADDR_W-1:0]    res_addr_q;
	logic                  res_used_q;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [FNUM_W-1:0]     out_frame_q;
	logic [PADDR_W-1:0]    out_addr_q;
	logic                  out_used_q;

	logic                  ram_wr_en;
	logic [ADDR_W-1:0]     ram_wr_addr;
	logic [WORD_BITS-1:0]  ram_wr_data;
	logic                  ram_rd_en;
	logic [ADDR_W-1:0]     ram_rd_addr;
	logic [WORD_BITS-1:0]  ram_rd_data;

	logic [LIM_W-1:0]      cfg_ext;
	logic [LIM_W-1:0]      max_ext;
	logic [LIM_W-1:0]      limit;
	logic [CMP_W-1:0]      limit_c;
	logic [CMP_W-1:0]      sel_frame;
	logic                  sel_in_range;
	logic                  accept;
	logic                  push;
	logic [LIM_W-1:0]      rem;
	logic [WORD_BITS-1:0]  issue_mask;
	logic                  issue_more;
	logic                  issue;
	logic [WORD_BITS-1:0]  free_bits;
	logic [WORD_BITS-1:0]  low_bit;
	logic                  hit;
	logic [LIM_W-1:0]      hit_frame;
	logic [RADDR_W-1:0]    hit_addr;
	logic                  scan_fail;
	logic [WORD_BITS-1:0]  rmw_mask;

	// effective frame limit: min(frames_in_use, MAX_FRAMES)
	assign cfg_ext = LIM_W'(cfg_q);
	assign max_ext = LIM_W'(MAX_FRAMES);
	assign limit   = (cfg_ext < max_ext) ? cfg_ext : max_ext;
	assign limit_c = CMP_W'(limit);

	// frame addressed by the request: from the address on free, else the number
	assign sel_frame    = (command == CMD_FREE) ? CMP_W'(phys_address >> FRAME_SHIFT)
	                                            : CMP_W'(frame_number);
	assign sel_in_range = sel_frame < limit_c;

	assign in_stall = (state_q != ST_IDLE) || res_pend_q;
	assign accept   = in_valid && !in_stall;
	assign push     = res_pend_q && (!out_valid_q || !out_stall);

	// scan: mask off frames at or above the limit in the word being issued
	assign rem        = limit - base_q;
	assign issue_mask = (rem >= LIM_W'(WORD_BITS)) ? {WORD_BITS{1'b1}}
	                    : ~({WORD_BITS{1'b1}} << rem[BIT_W-1:0]);
	assign issue_more = base_q < limit;

	// scan: lowest free bit of the word that came back
	assign free_bits = ~ram_rd_data & mask_s1;
	assign low_bit   = free_bits & (~free_bits + WORD_BITS'(1));
	assign hit       = vld_s1 && (|free_bits);
	assign hit_frame = base_s1 | LIM_W'(onehot_idx(low_bit));
	assign hit_addr  = RADDR_W'(hit_frame) << FRAME_SHIFT;
	assign issue     = (state_q == ST_SCAN) && issue_more && !hit;
	assign scan_fail = (state_q == ST_SCAN) && !hit && !issue_more;

	assign rmw_mask = WORD_BITS'(1) << bit_q;

	// bitmap port control
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = fill_q;
		ram_wr_data = {WORD_BITS{1'b1}};
		ram_rd_en   = 1'b0;
		ram_rd_addr = ADDR_W'(sel_frame >> BIT_W);
		unique case (state_q)
			ST_FILL: begin
				ram_wr_en = 1'b1;
			end
			ST_IDLE: begin
				ram_rd_en = accept && sel_in_range &&
				            (command == CMD_FREE || command == CMD_MARK ||
				             command == CMD_TEST);
			end
			ST_SCAN: begin
				ram_rd_en   = issue;
				ram_rd_addr = issue_w_q;
				ram_wr_en   = hit;
				ram_wr_addr = addr_s1;
				ram_wr_data = ram_rd_data | low_bit;
			end
			ST_RMW: begin
				ram_wr_addr = addr_s1;
				ram_wr_en   = (op_q != CMD_TEST);
				ram_wr_data = (op_q == CMD_FREE) ? (ram_rd_data & ~rmw_mask)
				                                 : (ram_rd_data | rmw_mask);
			end
			default: begin
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_FILL;
			fill_q     <= '0;
			vld_s1     <= 1'b0;
			res_pend_q <= 1'b0;
		end else begin
			if (push) begin
				res_pend_q <= 1'b0;
			end
			unique case (state_q)
				ST_FILL: begin
					fill_q <= fill_q + ADDR_W'(1);
					if (fill_q == ADDR_W'(NWORDS - 1)) begin
						fill_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_pend_q <= 1'b1;
						vld_s1     <= 1'b0;
						unique case (command)
							CMD_ALLOC: begin
								if (limit != '0) begin
									res_pend_q <= 1'b0;
									state_q    <= ST_SCAN;
								end
							end
							CMD_FREE, CMD_MARK, CMD_TEST: begin
								if (sel_in_range) begin
									res_pend_q <= 1'b0;
									state_q    <= ST_RMW;
								end
							end
							CMD_MARK_ALL: begin
								state_q <= ST_FILL;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					vld_s1 <= issue;
					if (hit || scan_fail) begin
						res_pend_q <= 1'b1;
						vld_s1     <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				ST_RMW: begin
					res_pend_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request fields, scan pointers and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= command;
			bit_q        <= sel_frame[BIT_W-1:0];
			addr_s1      <= ADDR_W'(sel_frame >> BIT_W);
			issue_w_q    <= '0;
			base_q       <= '0;
			res_status_q <= STATUS_OK;
			res_frame_q  <= '0;
			res_addr_q   <= '0;
			res_used_q   <= 1'b0;
			if (command == CMD_ALLOC && limit == '0) begin
				res_status_q <= STATUS_NO_FREE;
			end
			if (command == CMD_MARK && !sel_in_range) begin
				res_status_q <= STATUS_RANGE;
			end
		end
		if (issue) begin
			issue_w_q <= issue_w_q + ADDR_W'(1);
			base_q    <= base_q + LIM_W'(WORD_BITS);
			addr_s1   <= issue_w_q;
			base_s1   <= base_q;
			mask_s1   <= issue_mask;
		end
		if (hit) begin
			res_frame_q <= FNUM_W'(hit_frame);
			res_addr_q  <= PADDR_W'(hit_addr);
		end
		if (scan_fail) begin
			res_status_q <= STATUS_NO_FREE;
		end
		if (state_q == ST_RMW && op_q == CMD_TEST) begin
			res_used_q <= ram_rd_data[bit_q];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_status_q <= res_status_q;
			out_frame_q  <= res_frame_q;
			out_addr_q   <= res_addr_q;
			out_used_q   <= res_used_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign result_frame   = out_frame_q;
	assign result_address = out_addr_q;
	assign frame_used     = out_used_q;

	// bitmap store
	bfa_ram #(
		.WIDTH  (WORD_BITS),
		.DEPTH  (NWORDS),
		.ADDR_W (ADDR_W)
	) u_bitmap (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

endmodule

// ===== tb/sv/tb_bitmap_frame_allocator.sv =====
`timescale 1ns / 1ps
// tb_bitmap_frame_allocator: self-checking bench for the bitmap frame allocator.
// Sends directed and random frame requests, predicts every reply from a shadow
// bitmap and compares field by field. Depends on bfa_pkg and bitmap_frame_allocator.
module tb_bitmap_frame_allocator;
	import bfa_pkg::*;

	localparam int unsigned CLK_HALF      = 4;
	localparam int unsigned NUM_FRAMES    = MAX_FRAMES_DEF;
	localparam int unsigned SWEEP_CYCLES  = MAX_FRAMES_DEF / WORD_BITS_DEF;
	localparam int unsigned SETTLE_CYCLES = SWEEP_CYCLES + 16;
	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned PHASE_REQS    = 112;
	localparam int unsigned NUM_PHASES    = 10;
	localparam int unsigned CFG_MAX       = (1 << CFG_W) - 1;

	// command codes the block does not define
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_W'(CMD_MARK_ALL + 1);
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [FNUM_W-1:0]  frame_number;
		logic [PADDR_W-1:0] phys_address;
	} frame_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FNUM_W-1:0]   result_frame;
		logic [PADDR_W-1:0]  result_address;
		logic                frame_used;
	} frame_reply_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [CMD_W-1:0]    command = '0;
	logic [FNUM_W-1:0]   frame_number = '0;
	logic [PADDR_W-1:0]  phys_address = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [FNUM_W-1:0]   result_frame;
	logic [PADDR_W-1:0]  result_address;
	logic                frame_used;

	// shadow of the block: used bits and the frame count register
	logic [NUM_FRAMES-1:0] frame_map = '1;
	logic [CFG_W-1:0]      frame_count = '0;

	frame_req_t   req_backlog[$];
	frame_reply_t expected_replies[$];
	int unsigned  queued_reqs = 0;
	int unsigned  matched_replies = 0;
	int unsigned  mismatch_count = 0;
	int unsigned  cycle_count = 0;
	logic         req_fire = 1'b0;
	logic         reply_fire = 1'b0;
	bit           send_burst = 1'b0;
	bit           recv_burst = 1'b0;
	int unsigned  send_wait = 0;
	int unsigned  recv_wait = 3;

	bitmap_frame_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.frame_number  (frame_number),
		.phys_address  (phys_address),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.result_frame  (result_frame),
		.result_address(result_address),
		.frame_used    (frame_used)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// apply one request to the shadow bitmap and return the reply it must give
	function automatic frame_reply_t apply_frame_req(input frame_req_t r);
		frame_reply_t rep;
		int unsigned  lim;
		int unsigned  f;
		rep = '0;
		lim = (frame_count < NUM_FRAMES) ? frame_count : NUM_FRAMES;
		case (r.command)
			CMD_ALLOC: begin
				// first fit: lowest free frame below the limit
				rep.status = STATUS_NO_FREE;
				f = 0;
				while (f < lim && rep.status == STATUS_NO_FREE) begin
					if (!frame_map[f]) begin
						frame_map[f]       = 1'b1;
						rep.status         = STATUS_OK;
						rep.result_frame   = FNUM_W'(f);
						rep.result_address = PADDR_W'(f << FRAME_SHIFT_DEF);
					end
					f++;
				end
			end
			CMD_FREE: begin
				// out of range frames are dropped silently
				f = r.phys_address >> FRAME_SHIFT_DEF;
				if (f < lim)
					frame_map[f] = 1'b0;
			end
			CMD_MARK: begin
				if (r.frame_number < lim)
					frame_map[r.frame_number] = 1'b1;
				else
					rep.status = STATUS_RANGE;
			end
			CMD_TEST: begin
				rep.frame_used = (r.frame_number < lim) && frame_map[r.frame_number];
			end
			CMD_MARK_ALL: begin
				frame_map = '1;
			end
			default: begin
			end
		endcase
		return rep;
	endfunction

	// per-request wait, with occasional stretches of no waiting at all
	function automatic int unsigned draw_wait(inout bit burst);
		if ($urandom_range(0, 39) == 0)
			burst = !burst;
		return burst ? 0 : $urandom_range(0, 8);
	endfunction

	function automatic logic [PADDR_W-1:0] frame_addr(input logic [FNUM_W-1:0] f);
		return {f, FNUM_W'($urandom)};
	endfunction

	// mostly in range, biased low so allocations and tests collide with frees
	function automatic logic [FNUM_W-1:0] pick_frame(input int unsigned lim);
		int unsigned roll;
		roll = $urandom_range(0, 7);
		if (lim == 0 || roll == 0)
			return FNUM_W'($urandom_range(0, NUM_FRAMES - 1));
		if (roll == 1)
			return FNUM_W'(lim - 1 + $urandom_range(0, 1));
		if (roll < 4)
			return FNUM_W'($urandom_range(0, ((lim < 128) ? lim : 128) - 1));
		return FNUM_W'($urandom_range(0, lim - 1));
	endfunction

	task automatic queue_req(input logic [CMD_W-1:0] c, input logic [FNUM_W-1:0] fn,
			input logic [PADDR_W-1:0] pa);
		req_backlog.push_back('{c, fn, pa});
		queued_reqs++;
	endtask

	// wait for every reply, then long enough for a bitmap sweep to finish
	task automatic wait_drained();
		while (matched_replies != queued_reqs)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_frame_count(input int unsigned n);
		wait_drained();
		@(negedge clk);
		cfg_we      <= 1'b1;
		cfg_wdata   <= CFG_W'(n);
		frame_count  = CFG_W'(n);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int unsigned n_reqs);
		int unsigned       lim;
		int unsigned       pick;
		int unsigned       k;
		logic [FNUM_W-1:0] f;
		lim = (frame_count < NUM_FRAMES) ? frame_count : NUM_FRAMES;
		for (k = 0; k < n_reqs; k++) begin
			pick = $urandom_range(0, 99);
			f    = pick_frame(lim);
			if (pick < 30)
				queue_req(CMD_FREE, FNUM_W'($urandom),
					($urandom_range(0, 6) == 0) ? PADDR_W'($urandom) : frame_addr(f));
			else if (pick < 60)
				queue_req(CMD_ALLOC, FNUM_W'($urandom), PADDR_W'($urandom));
			else if (pick < 75)
				queue_req(CMD_TEST, f, PADDR_W'($urandom));
			else if (pick < 88)
				queue_req(CMD_MARK, f, PADDR_W'($urandom));
			else if (pick < 90)
				queue_req(CMD_MARK_ALL, FNUM_W'($urandom), PADDR_W'($urandom));
			else if (pick < 93)
				queue_req(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
					FNUM_W'($urandom), PADDR_W'($urandom));
			else
				queue_req(CMD_W'($urandom), FNUM_W'($urandom), PADDR_W'($urandom));
		end
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	// request driver: holds while stalled, waits its drawn gap, then sends
	always @(negedge clk) begin
		frame_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_fire) begin
			if (in_valid)
				send_wait = draw_wait(send_burst);
			if (send_wait > 0 || req_backlog.size() == 0) begin
				if (send_wait > 0)
					send_wait--;
				in_valid <= 1'b0;
			end else begin
				nxt = req_backlog.pop_front();
				command      <= nxt.command;
				frame_number <= nxt.frame_number;
				phys_address <= nxt.phys_address;
				in_valid     <= 1'b1;
			end
		end
	end

	// reply side: stall each reply for its drawn wait
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (reply_fire)
				recv_wait = draw_wait(recv_burst);
			if (out_valid && recv_wait > 0) begin
				out_stall <= 1'b1;
				recv_wait--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// monitor: check accepted replies, predict accepted requests
	always @(posedge clk) begin
		frame_reply_t want;
		if (!arst_n) begin
			req_fire   <= 1'b0;
			reply_fire <= 1'b0;
		end else begin
			req_fire   <= in_valid && !in_stall;
			reply_fire <= out_valid && !out_stall;
			if (out_valid && !out_stall) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: unexpected reply: expected none, got status %0d frame %0d",
						$time, status, result_frame);
					mismatch_count++;
				end else begin
					want = expected_replies.pop_front();
					matched_replies++;
					check_field("status", want.status, status);
					check_field("result_frame", want.result_frame, result_frame);
					check_field("result_address", want.result_address, result_address);
					check_field("frame_used", want.frame_used, frame_used);
				end
			end
			if (in_valid && !in_stall)
				expected_replies.push_back(apply_frame_req('{command, frame_number, phys_address}));
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int unsigned phase_counts[NUM_PHASES];
		int unsigned p;
		phase_counts = '{NUM_FRAMES, CFG_MAX, 1, 0, 64, 65, 200, NUM_FRAMES - 1, 1000,
			NUM_FRAMES};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// full range: allocation edges, frame zero, top frame, mark all
		set_frame_count(NUM_FRAMES);
		queue_req(CMD_ALLOC, '0, '0);              // reset state: nothing free
		queue_req(CMD_TEST, '0, '0);
		queue_req(CMD_FREE, '0, '0);
		queue_req(CMD_TEST, '0, '1);
		queue_req(CMD_FREE, '1, '1);               // top frame via all-ones address
		queue_req(CMD_ALLOC, '0, '0);              // frame zero is a real allocation
		queue_req(CMD_ALLOC, '1, '1);
		queue_req(CMD_ALLOC, '0, '0);
		queue_req(CMD_FREE, '0, frame_addr('1));
		queue_req(CMD_MARK, '1, '0);
		queue_req(CMD_TEST, '1, '0);
		queue_req(CMD_FREE, '0, frame_addr(FNUM_W'(100)));
		queue_req(CMD_MARK_ALL, '0, '0);
		queue_req(CMD_TEST, FNUM_W'(100), '0);
		queue_req(CMD_ALLOC, '0, '0);
		queue_req(CMD_UNUSED_LO, '1, '1);
		queue_req(CMD_W'(CMD_UNUSED_LO + 1), '1, '1);
		queue_req(CMD_UNUSED_HI, '1, '1);

		// tiny range: requests just past the limit
		set_frame_count(3);
		queue_req(CMD_FREE, '0, frame_addr(FNUM_W'(2)));
		queue_req(CMD_FREE, '0, frame_addr(FNUM_W'(3)));
		queue_req(CMD_MARK, FNUM_W'(3), '0);
		queue_req(CMD_TEST, FNUM_W'(3), '0);
		queue_req(CMD_MARK, '1, '0);
		queue_req(CMD_ALLOC, '0, '0);
		queue_req(CMD_TEST, FNUM_W'(2), '0);

		// random phases, each under its own frame count
		for (p = 0; p < NUM_PHASES; p++) begin
			set_frame_count(phase_counts[p]);
			random_phase(PHASE_REQS);
		end

		wait_drained();
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
